// ----- rtl/core/lpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpsd_pkg
// Types and codes shared by the length-prefix stream deframer modules.
// ----------------------------------------------------------------------------
package lpsd_pkg;

    localparam int CHAN_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    localparam logic [BYTE_W-1:0] LEN_SHORT_MAX = 8'hFD;
    localparam logic [BYTE_W-1:0] LEN_EXT_CODE  = 8'hFE;
    localparam logic [BYTE_W-1:0] LEN_BAD_CODE  = 8'hFF;

    typedef enum logic [0:0] {
        ACT_BYTE    = 1'b0,
        ACT_RESTART = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FAILED  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    typedef struct packed {
        action_t             action;
        logic [CHAN_W-1:0]   channel;
        logic [BYTE_W-1:0]   rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        kind_t               kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                first;
        logic                last;
    } out_item_t;

    typedef struct packed {
        phase_t              phase;
        logic [LEN_W-1:0]    remaining;
        logic [BYTE_W-1:0]   length_high;
        logic                at_first;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        phase:       PH_IDLE,
        remaining:   '0,
        length_high: '0,
        at_first:    1'b1
    };

endpackage

// ----- rtl/core/lpsd_state_file.sv -----
// ----------------------------------------------------------------------------
// lpsd_state_file
// Per-channel deframer state: one read port, one write port.
// ----------------------------------------------------------------------------
module lpsd_state_file #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      rd_idx,
    output lpsd_pkg::chan_state_t rd_state,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  lpsd_pkg::chan_state_t wr_state
);

    lpsd_pkg::chan_state_t state_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                state_reg[i] <= lpsd_pkg::CHAN_RESET;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_idx];

endmodule

// ----- rtl/core/lpsd_step.sv -----
// ----------------------------------------------------------------------------
// lpsd_step
// Next-state and result logic for one word on one channel.
// ----------------------------------------------------------------------------
module lpsd_step (
    input  lpsd_pkg::in_item_t    item,
    input  lpsd_pkg::chan_state_t cur,
    output lpsd_pkg::chan_state_t nxt,
    output logic                  res_valid,
    output lpsd_pkg::out_item_t   res
);

    logic [lpsd_pkg::LEN_W-1:0] start_len;
    logic                       do_start;
    logic                       pay_last;

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        do_start  = 1'b0;
        start_len = {{(lpsd_pkg::LEN_W - lpsd_pkg::BYTE_W){1'b0}}, item.rx_byte};
        pay_last  = (cur.remaining <= lpsd_pkg::LEN_W'(1));

        res.out_channel  = item.channel;
        res.kind         = lpsd_pkg::KIND_DATA;
        res.payload_byte = '0;
        res.first        = 1'b0;
        res.last         = 1'b0;

        if (item.action == lpsd_pkg::ACT_RESTART)
        begin
            nxt = lpsd_pkg::CHAN_RESET;
        end
        else
        begin
            case (cur.phase)
                lpsd_pkg::PH_FAILED:
                begin
                    // drop the word
                end
                lpsd_pkg::PH_LEN_HI:
                begin
                    nxt.length_high = item.rx_byte;
                    nxt.phase       = lpsd_pkg::PH_LEN_LO;
                end
                lpsd_pkg::PH_LEN_LO:
                begin
                    do_start  = 1'b1;
                    start_len = {cur.length_high, item.rx_byte};
                end
                lpsd_pkg::PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.kind         = lpsd_pkg::KIND_DATA;
                    res.payload_byte = item.rx_byte;
                    res.first        = cur.at_first;
                    res.last         = pay_last;
                    if (pay_last)
                    begin
                        nxt.remaining = '0;
                        nxt.phase     = lpsd_pkg::PH_IDLE;
                        nxt.at_first  = 1'b1;
                    end
                    else
                    begin
                        nxt.remaining = cur.remaining - lpsd_pkg::LEN_W'(1);
                        nxt.at_first  = 1'b0;
                    end
                end
                default:
                begin
                    // idle, and unused phase codes act as idle
                    if (item.rx_byte <= lpsd_pkg::LEN_SHORT_MAX)
                    begin
                        do_start = 1'b1;
                    end
                    else if (item.rx_byte == lpsd_pkg::LEN_EXT_CODE)
                    begin
                        nxt.phase = lpsd_pkg::PH_LEN_HI;
                    end
                    else
                    begin
                        nxt.phase = lpsd_pkg::PH_FAILED;
                        res_valid = 1'b1;
                        res.kind  = lpsd_pkg::KIND_BAD;
                    end
                end
            endcase

            if (do_start)
            begin
                nxt.at_first = 1'b1;
                if (start_len == '0)
                begin
                    nxt.phase = lpsd_pkg::PH_IDLE;
                    res_valid = 1'b1;
                    res.kind  = lpsd_pkg::KIND_EMPTY;
                    res.last  = 1'b1;
                end
                else
                begin
                    nxt.remaining = start_len;
                    nxt.phase     = lpsd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

endmodule

// ----- rtl/core/length_prefix_stream_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefix_stream_deframer
// Multi-channel deframer for length-prefixed byte streams.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                             Direction  Carries
//   --------  ----------------------------------  ---------  -------------------------
//   item      item_valid, item_stall, item        in         action, channel, rx_byte
//   result    result_valid, result_stall, result  out        channel, kind, byte, marks
//
// One word is taken per cycle while item_stall is low; a word's result passes
// through the input register, then the result register. The state lookup, update
// and write-back for a channel all happen in the same cycle, so back-to-back words
// on the same channel see each other's updates. Reset clears every channel to
// idle. A stalled result holds; words that give no result keep moving past it,
// and a word that gives a result waits in the input register until it frees.
//
module length_prefix_stream_deframer #(
    parameter int CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lpsd_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output lpsd_pkg::out_item_t result
);

    // The channel field is three bits wide, so at most eight channels are
    // reachable; higher settings of CHANNELS add no storage.
    localparam int NCH   = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [lpsd_pkg::CHAN_W:0] NCH_V = (lpsd_pkg::CHAN_W + 1)'(NCH);

    // input register
    logic               in_valid_reg;
    lpsd_pkg::in_item_t in_item_reg;

    // result register
    logic                out_valid_reg;
    lpsd_pkg::out_item_t out_item_reg;

    logic                  in_range;
    logic [IDX_W-1:0]      chan_idx;
    lpsd_pkg::chan_state_t cur_state;
    lpsd_pkg::chan_state_t nxt_state;
    logic                  step_res_valid;
    lpsd_pkg::out_item_t   step_res;
    logic                  res_valid;
    logic                  out_free;
    logic                  fire;

    assign in_range = ({1'b0, in_item_reg.channel} < NCH_V);
    assign chan_idx = in_item_reg.channel[IDX_W-1:0];

    lpsd_state_file #(
        .DEPTH (NCH),
        .IDX_W (IDX_W)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (chan_idx),
        .rd_state (cur_state),
        .wr_en    (fire && in_range),
        .wr_idx   (chan_idx),
        .wr_state (nxt_state)
    );

    lpsd_step u_step (
        .item      (in_item_reg),
        .cur       (cur_state),
        .nxt       (nxt_state),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    // Out-of-range channels are dropped silently.
    assign res_valid = step_res_valid && in_range;

    // Advance the held word unless it has a result and the result slot is
    // still occupied by a stalled one.
    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && (!res_valid || out_free);
    assign item_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || fire)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid && out_free)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
